// ----- rtl/bbc_pkg.sv -----
// Shared types and constants for the bracket balance checker.
// Depends on nothing; every rtl module imports it.
`timescale 1ns / 1ps

package bbc_pkg;

	// Bracket stack geometry
	localparam int STACK_DEPTH = 4096;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	// Front-to-back queue geometry
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Character codes
	localparam logic [7:0] CH_LROUND  = 8'h28; // (
	localparam logic [7:0] CH_RROUND  = 8'h29; // )
	localparam logic [7:0] CH_LSQUARE = 8'h5B; // [
	localparam logic [7:0] CH_RSQUARE = 8'h5D; // ]
	localparam logic [7:0] CH_LCURLY  = 8'h7B; // {
	localparam logic [7:0] CH_RCURLY  = 8'h7D; // }

	// Bracket kinds as stored on the stack
	localparam logic [1:0] KIND_ROUND  = 2'd0;
	localparam logic [1:0] KIND_SQUARE = 2'd1;
	localparam logic [1:0] KIND_CURLY  = 2'd2;
	localparam logic [1:0] KIND_NONE   = 2'd3;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_PUSH,
		OP_POP
	} op_t;

	typedef enum logic [2:0] {
		V_OK,
		V_WRONG,
		V_EMPTY,
		V_OPEN,
		V_OVERFLOW
	} verdict_t;

	// One classified item as it travels from front to back
	typedef struct packed {
		op_t        op;
		logic [1:0] kind;
		logic       last;
	} qent_t;

endpackage

// ----- rtl/bbc_front.sv -----
// Front end: accepts input bytes and classifies them into stack operations.
// Depends on bbc_pkg.
`timescale 1ns / 1ps

module bbc_front
	import bbc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] symbol,
	input  logic       last,
	output logic       q_valid,
	input  logic       q_ready,
	output qent_t      q_item
);

	logic  vld_s1;
	qent_t item_s1;
	qent_t item_c;

	always_comb begin
		item_c.last = last;
		case (symbol)
			CH_LROUND: begin
				item_c.op   = OP_PUSH;
				item_c.kind = KIND_ROUND;
			end
			CH_LSQUARE: begin
				item_c.op   = OP_PUSH;
				item_c.kind = KIND_SQUARE;
			end
			CH_LCURLY: begin
				item_c.op   = OP_PUSH;
				item_c.kind = KIND_CURLY;
			end
			CH_RROUND: begin
				item_c.op   = OP_POP;
				item_c.kind = KIND_ROUND;
			end
			CH_RSQUARE: begin
				item_c.op   = OP_POP;
				item_c.kind = KIND_SQUARE;
			end
			CH_RCURLY: begin
				item_c.op   = OP_POP;
				item_c.kind = KIND_CURLY;
			end
			default: begin
				item_c.op   = OP_NONE;
				item_c.kind = KIND_NONE;
			end
		endcase
	end

	assign s_tready = !vld_s1 || q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_c;
		end
	end

	assign q_valid = vld_s1;
	assign q_item  = item_s1;

endmodule

// ----- rtl/bbc_queue.sv -----
// Small FIFO that decouples the classifier from the stack engine.
// Depends on bbc_pkg.
`timescale 1ns / 1ps

module bbc_queue
	import bbc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  qent_t in_item,
	output logic  out_valid,
	input  logic  out_ready,
	output qent_t out_item
);

	qent_t             ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;

	assign in_ready  = (cnt_q != QCNT_W'(QDEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_item  = ent_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= in_item;
		end
	end

endmodule

// ----- rtl/bbc_back.sv -----
// Back end: bracket stack engine, fault latch and result register.
// Depends on bbc_pkg.
`timescale 1ns / 1ps

module bbc_back
	import bbc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	output logic       q_ready,
	input  qent_t      q_item,
	output logic       res_valid,
	input  logic       res_ready,
	output logic       res_balanced,
	output logic [2:0] res_verdict
);

	// Top of stack lives in top_q; memory holds the entries below it.
	logic [1:0]       mem_q [STACK_DEPTH];
	logic [CNT_W-1:0] count_q;
	logic [1:0]       top_q;
	verdict_t         fault_q;

	// Prefetched entry just below the top, with write bypass
	logic [1:0]       rd_q;
	logic             byp_hit_q;
	logic [1:0]       byp_data_q;
	logic [1:0]       below;

	logic             res_valid_q;
	logic             res_balanced_q;
	verdict_t         res_verdict_q;

	logic             out_free;
	logic             fire;
	logic [CNT_W-1:0] cnt_n;
	logic [CNT_W-1:0] cnt_d;
	logic [1:0]       top_n;
	verdict_t         fault_n;
	verdict_t         verdict_n;
	logic             we;
	logic [ADDR_W-1:0] wa;
	logic [ADDR_W-1:0] ra;
	logic [CNT_W-1:0] ra_full;

	assign below    = byp_hit_q ? byp_data_q : rd_q;
	assign out_free = !res_valid_q || res_ready;
	assign fire     = q_valid && (!q_item.last || out_free);
	assign q_ready  = fire;

	always_comb begin
		cnt_n   = count_q;
		top_n   = top_q;
		fault_n = fault_q;
		we      = 1'b0;
		if (fire && fault_q == V_OK) begin
			case (q_item.op)
				OP_PUSH: begin
					if (count_q == CNT_W'(STACK_DEPTH)) begin
						fault_n = V_OVERFLOW;
					end else begin
						we    = (count_q != '0);
						top_n = q_item.kind;
						cnt_n = count_q + 1'b1;
					end
				end
				OP_POP: begin
					if (count_q == '0) begin
						fault_n = V_EMPTY;
					end else begin
						cnt_n = count_q - 1'b1;
						top_n = below;
						if (top_q != q_item.kind) begin
							fault_n = V_WRONG;
						end
					end
				end
				default: begin
				end
			endcase
		end
		if (fault_n != V_OK) begin
			verdict_n = fault_n;
		end else if (cnt_n != '0) begin
			verdict_n = V_OPEN;
		end else begin
			verdict_n = V_OK;
		end
		cnt_d   = (fire && q_item.last) ? '0 : cnt_n;
		wa      = ADDR_W'(count_q - 1'b1);
		ra_full = cnt_d - CNT_W'(2);
		ra      = ra_full[ADDR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			fault_q     <= V_OK;
			res_valid_q <= 1'b0;
		end else begin
			count_q <= cnt_d;
			fault_q <= (fire && q_item.last) ? V_OK : fault_n;
			if (out_free) begin
				res_valid_q <= fire && q_item.last;
			end
		end
	end

	always_ff @(posedge clk) begin
		top_q      <= top_n;
		rd_q       <= mem_q[ra];
		byp_hit_q  <= we && (wa == ra);
		byp_data_q <= top_q;
		if (we) begin
			mem_q[wa] <= top_q;
		end
		if (out_free && fire && q_item.last) begin
			res_balanced_q <= (verdict_n == V_OK);
			res_verdict_q  <= verdict_n;
		end
	end

	assign res_valid    = res_valid_q;
	assign res_balanced = res_balanced_q;
	assign res_verdict  = res_verdict_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count above depth");

	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		fire && q_item.last |=> count_q == '0 && fault_q == V_OK)
		else $error("state not cleared after final byte");

	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fault_q != V_OK && !(fire && q_item.last) |=> fault_q == $past(fault_q))
		else $error("latched fault changed within a string");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !q_item.last && q_item.op == OP_PUSH && fault_q == V_OK &&
		count_q != CNT_W'(STACK_DEPTH) |=> count_q == $past(count_q) + 1'b1)
		else $error("push did not grow the stack");

endmodule

// ----- rtl/bracket_balance_checker_core.sv -----
// Bracket balance checker top level: ties classifier, queue and stack engine.
// Depends on bbc_pkg, bbc_front, bbc_queue and bbc_back.
`timescale 1ns / 1ps

// Checks that round, square and curly brackets in a byte string nest and match.
// Send the string one byte per item on the s_ side, with s_tlast set on the
// final byte; non-bracket bytes are ignored. Exactly one result item comes
// out on the m_ side for each final byte: a balanced flag and a verdict code
// (0 ok, 1 wrong closer, 2 closer on an empty stack, 3 openers left open,
// 4 stack overflow). The first fault in a string wins; later bytes are
// skipped until the final one, after which the state is clear for the next
// string. Throughput is one byte per clock, sustained, including runs of
// closers, while the queue has room: the top of the stack sits in a register
// and the entry under it is prefetched from the 4096 x 2 bit stack memory
// (one write port, one registered read port) every cycle. The final byte of
// a string is taken into the input register, then written into the queue,
// and then turned into a result by the stack engine, which raises m_tvalid.
// A four-item queue between the classifier and the stack engine lets the
// input keep flowing while a result waits on m_tready. No clearing pass is
// needed after reset; the stack is tracked by its count alone.

module bracket_balance_checker_core
	import bbc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] symbol
	input  logic       s_tlast,  // last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata   // [0] balanced, [3:1] verdict, [7:4] zero
);

	logic       fq_valid;
	logic       fq_ready;
	qent_t      fq_item;
	logic       qb_valid;
	logic       qb_ready;
	qent_t      qb_item;
	logic       res_balanced;
	logic [2:0] res_verdict;

	bbc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.symbol   (s_tdata),
		.last     (s_tlast),
		.q_valid  (fq_valid),
		.q_ready  (fq_ready),
		.q_item   (fq_item)
	);

	bbc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_item   (fq_item),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_item  (qb_item)
	);

	bbc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (qb_valid),
		.q_ready      (qb_ready),
		.q_item       (qb_item),
		.res_valid    (m_tvalid),
		.res_ready    (m_tready),
		.res_balanced (res_balanced),
		.res_verdict  (res_verdict)
	);

	// Pack result fields, lowest bit first, zero-filled to a byte
	assign m_tdata = {4'b0000, res_verdict, res_balanced};

endmodule

// ----- tb/bracket_verdict_monitor.sv -----
// Watches both stream channels of the bracket balance checker, keeps its own
// shadow stack to predict each verdict, and compares every result item.
// Depends on bbc_pkg for character codes, bracket kinds and verdict codes.
`timescale 1ns / 1ps

module bracket_verdict_monitor
	import bbc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,     // [7:0] symbol
	input  logic       s_tlast,     // last
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,     // [0] balanced, [3:1] verdict, [7:4] zero
	output int         outstanding,
	output int         fail_count
);

	typedef struct packed {
		logic     balanced;
		verdict_t verdict;
	} verdict_item_t;

	verdict_item_t verdicts_due[$];

	// shadow copy of the bracket stack and the latched fault
	logic [1:0] kind_stack [STACK_DEPTH];
	int unsigned depth_now;
	verdict_t fault_now;
	int errs;

	task automatic track_symbol(input logic [7:0] sym, input logic fin);
		logic [1:0] kind;
		logic opens;
		logic closes;
		verdict_t v;
		opens = 1'b0;
		closes = 1'b0;
		kind = KIND_NONE;
		case (sym)
			CH_LROUND:  begin opens = 1'b1;  kind = KIND_ROUND;  end
			CH_LSQUARE: begin opens = 1'b1;  kind = KIND_SQUARE; end
			CH_LCURLY:  begin opens = 1'b1;  kind = KIND_CURLY;  end
			CH_RROUND:  begin closes = 1'b1; kind = KIND_ROUND;  end
			CH_RSQUARE: begin closes = 1'b1; kind = KIND_SQUARE; end
			CH_RCURLY:  begin closes = 1'b1; kind = KIND_CURLY;  end
			default: ;
		endcase
		// once a fault is latched, everything up to the final byte is skipped
		if (fault_now == V_OK) begin
			if (opens) begin
				if (depth_now >= STACK_DEPTH) begin
					fault_now = V_OVERFLOW;
				end else begin
					kind_stack[depth_now] = kind;
					depth_now++;
				end
			end else if (closes) begin
				if (depth_now == 0) begin
					fault_now = V_EMPTY;
				end else begin
					// mismatched closer still pops
					depth_now--;
					if (kind_stack[depth_now] != kind)
						fault_now = V_WRONG;
				end
			end
		end
		if (fin) begin
			if (fault_now != V_OK)
				v = fault_now;
			else if (depth_now != 0)
				v = V_OPEN;
			else
				v = V_OK;
			verdicts_due.push_back('{balanced: 1'(v == V_OK), verdict: v});
			depth_now = 0;
			fault_now = V_OK;
		end
	endtask

	task automatic check_result(input logic [7:0] word);
		verdict_item_t want;
		if (verdicts_due.size() == 0) begin
			$error("result item with no verdict pending: tdata=%h", word);
			errs++;
		end else begin
			want = verdicts_due.pop_front();
			if (word[0] !== want.balanced) begin
				$error("balanced: expected %0d, actual %0d", want.balanced, word[0]);
				errs++;
			end
			if (word[3:1] !== want.verdict) begin
				$error("verdict: expected %0d, actual %0d", want.verdict, word[3:1]);
				errs++;
			end
			if (word[7:4] !== 4'd0) begin
				$error("pad: expected 0, actual %h", word[7:4]);
				errs++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdicts_due.delete();
			depth_now = 0;
			fault_now = V_OK;
			errs = 0;
			outstanding <= 0;
			fail_count <= 0;
		end else begin
			// results can never belong to an item taken in the same cycle
			if (m_tvalid && m_tready)
				check_result(m_tdata);
			if (s_tvalid && s_tready)
				track_symbol(s_tdata, s_tlast);
			outstanding <= verdicts_due.size();
			fail_count <= errs;
		end
	end

endmodule

// ----- tb/tb_bracket_balance_checker_core.sv -----
// Testbench top for bracket_balance_checker_core: clock, reset, string stimulus,
// receiver stall patterns and the final verdict.
// Depends on bbc_pkg, the rtl top level and bracket_verdict_monitor.
`timescale 1ns / 1ps

module tb_bracket_balance_checker_core;
	import bbc_pkg::*;

	localparam int RANDOM_ITEMS = 1430;  // plus directed and pressure bytes
	localparam int HOLD_CYCLES  = 400;   // one long receiver hold-off
	localparam int PRESS_STRS   = 100;   // short strings offered during it
	localparam int TAIL_CYCLES  = 8;     // idle margin after the last verdict

	typedef enum int {
		RX_OPEN,      // always ready
		RX_COIN,      // ready half the time
		RX_SPARSE,    // ready one cycle in four on average
		RX_PERIODIC   // two ready, one stalled
	} stall_mode_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;   // [7:0] symbol
	logic       s_tlast = 1'b0;    // last
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;           // [0] balanced, [3:1] verdict, [7:4] zero

	int outstanding;
	int fail_count;

	// sender burst state
	int burst_left = 0;
	bit no_gaps = 1'b0;
	int random_bytes = 0;

	// asks the receiver process for its long hold-off
	logic hold_req = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	bracket_balance_checker_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	bracket_verdict_monitor monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	function automatic logic [7:0] open_char(input logic [1:0] kind);
		case (kind)
			KIND_ROUND:  return CH_LROUND;
			KIND_SQUARE: return CH_LSQUARE;
			default:     return CH_LCURLY;
		endcase
	endfunction

	function automatic logic [7:0] close_char(input logic [1:0] kind);
		case (kind)
			KIND_ROUND:  return CH_RROUND;
			KIND_SQUARE: return CH_RSQUARE;
			default:     return CH_RCURLY;
		endcase
	endfunction

	// Offers one item and returns at the edge where it was taken. The sender
	// works in bursts; between bursts tvalid drops for a random gap, and some
	// bursts follow on with no gap at all. tvalid is never dropped and raised
	// in the same step.
	task automatic put_byte(input logic [7:0] sym, input logic fin);
		int gap;
		if (burst_left == 0) begin
			gap = (no_gaps || $urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= sym;
		s_tlast  <= fin;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
	endtask

	// whole string, last flag on its final byte
	task automatic send_text(input string txt);
		for (int i = 0; i < txt.len(); i++)
			put_byte(txt[i], i == txt.len() - 1);
	endtask

	// sender goes quiet until every verdict it caused has come back
	task automatic wait_all_verdicts();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// Mostly well-formed nesting with noise bytes mixed in; the rest is pure
	// noise, strings left open, a corrupted bracket or a stray closer.
	task automatic send_random_string();
		logic [7:0] txt[$];
		logic [1:0] opens[$];
		logic [1:0] kind;
		int style;
		int steps;
		int pick;
		style = $urandom_range(0, 9);
		if (style == 0) begin
			steps = $urandom_range(1, 12);
			repeat (steps) txt.push_back(8'($urandom_range(0, 255)));
		end else begin
			steps = $urandom_range(0, 28);
			repeat (steps) begin
				pick = $urandom_range(0, 9);
				if (pick < 2) begin
					txt.push_back(8'($urandom_range(0, 255)));
				end else if (pick < 6 && opens.size() != 0) begin
					txt.push_back(close_char(opens.pop_back()));
				end else begin
					kind = 2'($urandom_range(0, 2));
					opens.push_back(kind);
					txt.push_back(open_char(kind));
				end
			end
			// one string in five keeps its open brackets
			if ($urandom_range(0, 4) != 0)
				while (opens.size() != 0) txt.push_back(close_char(opens.pop_back()));
			kind = 2'($urandom_range(0, 2));
			if (style == 1 && txt.size() != 0) begin
				pick = $urandom_range(0, txt.size() - 1);
				txt[pick] = $urandom_range(0, 1) ? open_char(kind) : close_char(kind);
			end else if (style == 2) begin
				txt.push_back(close_char(kind));
			end
		end
		if (txt.size() == 0)
			txt.push_back(8'($urandom_range(0, 255)));
		foreach (txt[i])
			put_byte(txt[i], i == txt.size() - 1);
		random_bytes += txt.size();
	endtask

	// Receiver: segments of different stall patterns, plus one long hold-off
	// on request while the sender keeps offering items.
	initial begin : rx_pattern
		stall_mode_t mode;
		int seg_len;
		bit held;
		held = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req && !held) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				mode = stall_mode_t'($urandom_range(0, 3));
				seg_len = $urandom_range(4, 40);
				for (int k = 0; k < seg_len; k++) begin
					case (mode)
						RX_OPEN:   m_tready <= 1'b1;
						RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
						RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
						default:   m_tready <= (k % 3 != 2);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// Guard against a hang; far above the slowest correct run.
	initial begin
		#8_000_000;
		$display("tb_bracket_balance_checker_core: done, errors");
		$finish;
	end

	initial begin : stimulus
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: symbol extremes, each bracket, each verdict but overflow
		put_byte(8'h00, 1'b1);                 // lone null byte: ok
		put_byte(CH_LROUND, 1'b0);
		put_byte(8'hFF, 1'b0);                 // noise inside a pair
		put_byte(CH_RROUND, 1'b1);
		send_text("[{}]");                     // nested, ok
		send_text("(]((");                     // wrong closer, rest skipped
		send_text(")(");                       // closer on empty stack
		send_text("{[");                       // openers left open
		send_text("}");                        // empty-stack closer as final byte
		send_text("([)]");                     // crossed pairs
		send_text("()");                       // state cleared after a fault
		wait_all_verdicts();

		// long receiver hold-off: short strings back to back fill the
		// internal queue until the input stalls
		hold_req <= 1'b1;
		no_gaps = 1'b1;
		for (int i = 0; i < PRESS_STRS; i++)
			send_text(i % 2 ? "[]" : "(x");
		hold_req <= 1'b0;
		no_gaps = 1'b0;
		wait_all_verdicts();

		// random strings, with an occasional full drain
		while (random_bytes < RANDOM_ITEMS) begin
			send_random_string();
			if ($urandom_range(0, 39) == 0)
				wait_all_verdicts();
		end

		wait_all_verdicts();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb_bracket_balance_checker_core: done, clean");
		else
			$display("tb_bracket_balance_checker_core: done, errors");
		$finish;
	end

endmodule
